// ----- rtl/set_assoc_cache_lru_writeback_core_assert.svh -----
// Assertion macros used by the cache tag store checker
`ifndef SET_ASSOC_CACHE_LRU_WRITEBACK_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_WRITEBACK_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SAC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SAC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sac_pkg.sv -----
// Shared types and constants of the set-associative cache tag store
package sac_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int NUM_WAYS_DEF = 8;
  localparam int AGE_BITS_DEF = 16;

  localparam int ADDR_W    = 32;
  localparam int WAY_OUT_W = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SET_RAW_W = 7;
  localparam int SET_TAB_N = 1 << SET_RAW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  localparam logic [3:0] WAYS_RST   = 4'd4;
  localparam logic [2:0] INDEX_RST  = 3'd3;
  localparam logic [3:0] OFFSET_RST = 4'd3;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } sac_in_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 writeback;
    logic [ADDR_W-1:0]    victim_address;
  } sac_out_t;

  typedef struct packed {
    logic valid;
    logic match;
    logic newer;
  } sac_way_stat_t;

endpackage

// ----- rtl/sac_line_ram.sv -----
// Line store: one write port, one registered read port
module sac_line_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 50
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sac_way_unit.sv -----
// Shared per-way unit: tag compare, age update, age compare against best
module sac_way_unit import sac_pkg::*; #(
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic                valid_i,
  input  logic                dirty_i,
  input  logic [AGE_BITS-1:0] age_i,
  input  logic [ADDR_W-1:0]   tag_i,
  input  logic [ADDR_W-1:0]   blk_i,
  input  logic                write_i,
  input  logic [AGE_BITS-1:0] best_age_i,
  output sac_way_stat_t       stat_o,
  output logic [AGE_BITS-1:0] age_o,
  output logic                dirty_o
);

  logic match;

  assign match = valid_i && (tag_i == blk_i);

  always_comb begin
    if (match) begin
      age_o = '0;
    end else if (&age_i) begin
      age_o = age_i;
    end else begin
      age_o = age_i + AGE_BITS'(1);
    end
  end

  assign dirty_o      = dirty_i | (match & write_i);
  assign stat_o.valid = valid_i;
  assign stat_o.match = match;
  assign stat_o.newer = age_o > best_age_i;

endmodule

// ----- rtl/set_assoc_cache_lru_writeback_core.sv -----
// Tag store of a set-associative write-back write-allocate cache, age LRU
// One access in flight: a new beat is taken only in the idle state, after the
// previous result has been loaded into the output register.
// The ways of a set are walked one per cycle through the line store's single
// read port and the shared way unit. After reset a clearing pass zeroes all
// NUM_SETS * NUM_WAYS lines of the line store; no access is taken meanwhile.
module set_assoc_cache_lru_writeback_core import sac_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sac_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sac_out_t             out_data_o
);

  localparam int LINES  = NUM_SETS * NUM_WAYS;
  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int CNT_W  = $clog2(NUM_WAYS + 1);
  localparam int DATA_W = ADDR_W + AGE_BITS + 2;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_BASE  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_FILL  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]           ways_q, ways_d;
  logic [2:0]           ib_q, ib_d;
  logic [3:0]           off_q, off_d;
  logic [LINE_W-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0]     rd_q, rd_d;
  logic                 pv_q, pv_d;
  logic                 hit_q, hit_d;
  logic                 inv_q, inv_d;
  logic                 out_valid_q, out_valid_d;

  logic                 func_q, func_d;
  logic [ADDR_W-1:0]    blk_q, blk_d;
  logic [SET_RAW_W-1:0] setraw_q, setraw_d;
  logic [CNT_W-1:0]     nways_q, nways_d;
  logic [LINE_W-1:0]    base_q, base_d;
  logic [WAY_W-1:0]     pw_q, pw_d;
  logic [WAY_W-1:0]     hway_q, hway_d;
  logic [WAY_W-1:0]     inv_way_q, inv_way_d;
  logic [AGE_BITS-1:0]  best_age_q, best_age_d;
  logic [WAY_W-1:0]     best_way_q, best_way_d;
  logic                 best_dirty_q, best_dirty_d;
  logic [ADDR_W-1:0]    best_tag_q, best_tag_d;
  sac_out_t             out_q, out_d;

  logic [SET_W-1:0]     set_tab [SET_TAB_N];
  logic [ADDR_W-1:0]    shifted;
  logic                 rd_issue;
  logic                 last;
  logic [WAY_W-1:0]     fin_way;
  logic [WAY_W-1:0]     res_way;
  logic                 res_wb;

  logic                 ram_we;
  logic [LINE_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [LINE_W-1:0]    ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  sac_way_stat_t        wstat;
  logic [AGE_BITS-1:0]  wage;
  logic                 wdirty;

  for (genvar g = 0; g < SET_TAB_N; g++) begin : g_set_tab
    assign set_tab[g] = SET_W'(g % NUM_SETS);
  end

  sac_line_ram #(
    .DEPTH  (LINES),
    .ADDR_W (LINE_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sac_way_unit #(
    .AGE_BITS (AGE_BITS)
  ) u_way (
    .valid_i    (ram_rdata[DATA_W-1]),
    .dirty_i    (ram_rdata[DATA_W-2]),
    .age_i      (ram_rdata[ADDR_W +: AGE_BITS]),
    .tag_i      (ram_rdata[ADDR_W-1:0]),
    .blk_i      (blk_q),
    .write_i    (func_q),
    .best_age_i (best_age_q),
    .stat_o     (wstat),
    .age_o      (wage),
    .dirty_o    (wdirty)
  );

  assign shifted   = in_data_i.address >> off_q;
  assign rd_issue  = (state_q == ST_SCAN) && (rd_q < nways_q);
  assign ram_raddr = base_q + LINE_W'(rd_q[WAY_W-1:0]);
  assign last      = pv_q && (CNT_W'(pw_q) == nways_q - CNT_W'(1));
  assign fin_way   = inv_q ? inv_way_q : best_way_q;
  assign res_way   = hit_q ? hway_q : fin_way;
  assign res_wb    = !hit_q && !inv_q && best_dirty_q;

  always_comb begin
    ways_d = ways_q;
    ib_d   = ib_q;
    off_d  = off_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAYS:   ways_d = cfg_wdata_i;
        CFG_INDEX:  ib_d   = cfg_wdata_i[2:0];
        CFG_OFFSET: off_d  = cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rd_d         = rd_q;
    pv_d         = rd_issue;
    hit_d        = hit_q;
    inv_d        = inv_q;
    out_valid_d  = out_valid_q && out_stall_i;
    func_d       = func_q;
    blk_d        = blk_q;
    setraw_d     = setraw_q;
    nways_d      = nways_q;
    base_d       = base_q;
    pw_d         = rd_q[WAY_W-1:0];
    hway_d       = hway_q;
    inv_way_d    = inv_way_q;
    best_age_d   = best_age_q;
    best_way_d   = best_way_q;
    best_dirty_d = best_dirty_q;
    best_tag_d   = best_tag_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = base_q + LINE_W'(pw_q);
    ram_wdata    = {1'b1, wdirty, wage, ram_rdata[ADDR_W-1:0]};

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + LINE_W'(1);
        if (clr_q == LINE_W'(LINES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_data_i.func;
          blk_d    = in_data_i.address & ({ADDR_W{1'b1}} << off_q);
          setraw_d = shifted[SET_RAW_W-1:0] & ~({SET_RAW_W{1'b1}} << ib_q);
          if (ways_q == 4'd0) begin
            nways_d = CNT_W'(1);
          end else if ({1'b0, ways_q} > 5'(NUM_WAYS)) begin
            nways_d = CNT_W'(NUM_WAYS);
          end else begin
            nways_d = CNT_W'(ways_q);
          end
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        base_d  = LINE_W'(set_tab[setraw_q]) * LINE_W'(NUM_WAYS);
        rd_d    = '0;
        hit_d   = 1'b0;
        inv_d   = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_issue) begin
          rd_d = rd_q + CNT_W'(1);
        end
        if (pv_q) begin
          ram_we = wstat.valid;
          if (wstat.match && !hit_q) begin
            hit_d  = 1'b1;
            hway_d = pw_q;
          end
          if (!wstat.valid && !inv_q) begin
            inv_d     = 1'b1;
            inv_way_d = pw_q;
          end
          if (pw_q == '0 || wstat.newer) begin
            best_age_d   = wage;
            best_way_d   = pw_q;
            best_dirty_d = ram_rdata[DATA_W-2];
            best_tag_d   = ram_rdata[ADDR_W-1:0];
          end
        end
        if (last) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we    = !hit_q;
        ram_waddr = base_q + LINE_W'(fin_way);
        ram_wdata = {1'b1, func_q, {AGE_BITS{1'b0}}, blk_q};
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.hit            = hit_q;
          out_d.way_used       = WAY_OUT_W'(res_way);
          out_d.writeback      = res_wb;
          out_d.victim_address = res_wb ? best_tag_q : '0;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ways_q      <= WAYS_RST;
      ib_q        <= INDEX_RST;
      off_q       <= OFFSET_RST;
      clr_q       <= '0;
      rd_q        <= '0;
      pv_q        <= 1'b0;
      hit_q       <= 1'b0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ways_q      <= ways_d;
      ib_q        <= ib_d;
      off_q       <= off_d;
      clr_q       <= clr_d;
      rd_q        <= rd_d;
      pv_q        <= pv_d;
      hit_q       <= hit_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    blk_q        <= blk_d;
    setraw_q     <= setraw_d;
    nways_q      <= nways_d;
    base_q       <= base_d;
    pw_q         <= pw_d;
    hway_q       <= hway_d;
    inv_way_q    <= inv_way_d;
    best_age_q   <= best_age_d;
    best_way_q   <= best_way_d;
    best_dirty_q <= best_dirty_d;
    best_tag_q   <= best_tag_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/sac_checker.sv -----
// Port-level checker for the cache tag store, bound to the top level
`include "set_assoc_cache_lru_writeback_core_assert.svh"

module sac_checker import sac_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sac_out_t out_data_o
);

  `SAC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `SAC_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken again right after a beat")
  `SAC_ASSERT_IMP(a_hit_no_wb, clk_i, rst_ni, out_valid_o, !(out_data_o.hit && out_data_o.writeback), "write-back reported on a hit")
  `SAC_ASSERT_IMP(a_victim_zero, clk_i, rst_ni, out_valid_o && !out_data_o.writeback, out_data_o.victim_address == '0, "victim address set without write-back")

endmodule

bind set_assoc_cache_lru_writeback_core sac_checker u_sac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
